// File: src/standard_script_classifier_macros.svh
// assertion macros for the standard script classifier
`ifndef STANDARD_SCRIPT_CLASSIFIER_MACROS_SVH
`define STANDARD_SCRIPT_CLASSIFIER_MACROS_SVH
`ifndef ASSERT_OFF
`define SSC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define SSC_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden condition");
`else
`define SSC_ASSERT(lbl, clk, rstn, prop)
`define SSC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: src/ssc_pkg.sv
// shared types and constants of the standard script classifier
`default_nettype none
package ssc_pkg;
  localparam int MAX_SCRIPT_BYTES = 16384;
  localparam int MAX_KEYS = 16;
  localparam int KEY_DEPTH = 32;
  localparam int KEY_AW = $clog2(KEY_DEPTH);
  localparam int JOB_DEPTH = 2;
  localparam int JOB_AW = $clog2(JOB_DEPTH);

  localparam logic [2:0] TYPE_NONSTD = 3'd0;
  localparam logic [2:0] TYPE_PUBKEY = 3'd1;
  localparam logic [2:0] TYPE_PKH    = 3'd2;
  localparam logic [2:0] TYPE_SH     = 3'd3;
  localparam logic [2:0] TYPE_MULTI  = 3'd4;
  localparam logic [2:0] TYPE_NULL   = 3'd5;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_RANGE = 2'd1;
  localparam logic [1:0] KIND_SMALL = 2'd2;

  localparam logic [4:0] CAP_RESET = 5'd20;

  typedef struct packed {
    logic [7:0]  script_byte;
    logic [14:0] script_length;
  } in_t;

  typedef struct packed {
    logic [2:0]  script_type;
    logic        matched;
    logic [4:0]  solution_index;
    logic [1:0]  solution_kind;
    logic [13:0] solution_offset;
    logic [6:0]  solution_length;
    logic [4:0]  small_value;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [13:0] offset;
    logic        is_long;
  } key_t;

  typedef struct packed {
    logic [2:0]  script_type;
    logic        matched;
    logic [1:0]  kind;
    logic [13:0] offset;
    logic [6:0]  length;
    logic        is_multi;
    logic [4:0]  m;
    logic [4:0]  n;
    logic [4:0]  nkeys;
  } job_t;

  typedef struct packed {
    logic key_full;
    logic job_full;
    logic key_valid;
    logic job_valid;
  } q_status_t;

  typedef enum logic [2:0] {
    PH_OP, PH_L1, PH_L2A, PH_L2B, PH_L4A, PH_L4B, PH_L4C, PH_L4D
  } push_phase_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_ROWS, BK_DRAIN
  } back_state_e;
endpackage
`default_nettype wire

// File: src/standard_script_classifier.sv
// top level of the standard script classifier
// usage:
//   input channel in_valid_i / in_stall_o / in_data_i carries one script byte per
//   transaction together with the script's total length; a script ends on the byte
//   whose position reaches that length
//   output channel out_valid_o / out_stall_i / out_data_o carries one result row per
//   transaction; every script yields one or more rows, the final one marked last_result
//   cfg_we_i / cfg_data_i write solution_capacity, only while the block is idle
// timing:
//   one byte is accepted per cycle while the parser is not held off; the parser
//   holds off when the key queue (32 entries) or the job queue (2 scripts) is full
//   the first row of a script passes through the job queue, the emitter's job register and
//   the output register; the emitter takes a job, then emits its rows (n+2 for multisig),
//   then drops each stored key for non-multisig scripts with keys
// reset:
//   clears the parser, both queues, the emitter state and the output valid flag; capacity returns to 20
// stall:
//   a stalled row holds on out_data_o; the emitter and then the queues back up, and
//   the parser keeps taking bytes until a queue fills
`default_nettype none
module standard_script_classifier (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [4:0]    cfg_data_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ssc_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ssc_pkg::out_t      out_data_o
);
  ssc_pkg::q_status_t status;
  ssc_pkg::key_t key_in, key_head;
  ssc_pkg::job_t job_in, job_head;
  logic key_push, key_pop, job_push, job_pop, take;

  // hold off bytes while either queue has no room
  assign in_stall_o = status.key_full || status.job_full;
  assign take = in_valid_i && !in_stall_o;

  ssc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .take_i(take), .in_i(in_data_i),
    .key_push_o(key_push), .key_o(key_in),
    .job_push_o(job_push), .job_o(job_in)
  );

  ssc_queue u_queue (
    .clk_i, .rst_ni,
    .key_push_i(key_push), .key_i(key_in), .key_pop_i(key_pop), .key_o(key_head),
    .job_push_i(job_push), .job_i(job_in), .job_pop_i(job_pop), .job_o(job_head),
    .status_o(status)
  );

  ssc_back u_back (
    .clk_i, .rst_ni, .status_i(status),
    .job_i(job_head), .job_pop_o(job_pop),
    .key_i(key_head), .key_pop_o(key_pop),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .data_o(out_data_o)
  );
endmodule
`default_nettype wire

// File: src/ssc_queue.sv
// job and key queues between the parser and the result emitter
`default_nettype none
`include "standard_script_classifier_macros.svh"
module ssc_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             key_push_i,
  input  wire ssc_pkg::key_t    key_i,
  input  wire logic             key_pop_i,
  output ssc_pkg::key_t         key_o,
  input  wire logic             job_push_i,
  input  wire ssc_pkg::job_t    job_i,
  input  wire logic             job_pop_i,
  output ssc_pkg::job_t         job_o,
  output ssc_pkg::q_status_t    status_o
);
  ssc_pkg::key_t key_mem [ssc_pkg::KEY_DEPTH];
  logic [ssc_pkg::KEY_AW-1:0] kwr_q, krd_q;
  logic [ssc_pkg::KEY_AW:0] kcnt_q;
  ssc_pkg::job_t job_mem [ssc_pkg::JOB_DEPTH];
  logic [ssc_pkg::JOB_AW-1:0] jwr_q, jrd_q;
  logic [ssc_pkg::JOB_AW:0] jcnt_q;

  always_ff @(posedge clk_i) begin
    if (key_push_i) key_mem[kwr_q] <= key_i;
    if (job_push_i) job_mem[jwr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kwr_q <= '0; krd_q <= '0; kcnt_q <= '0;
      jwr_q <= '0; jrd_q <= '0; jcnt_q <= '0;
    end else begin
      if (key_push_i) kwr_q <= kwr_q + 1'b1;
      if (key_pop_i) krd_q <= krd_q + 1'b1;
      kcnt_q <= kcnt_q + {{ssc_pkg::KEY_AW{1'b0}}, key_push_i}
                       - {{ssc_pkg::KEY_AW{1'b0}}, key_pop_i};
      if (job_push_i) jwr_q <= jwr_q + 1'b1;
      if (job_pop_i) jrd_q <= jrd_q + 1'b1;
      jcnt_q <= jcnt_q + {{ssc_pkg::JOB_AW{1'b0}}, job_push_i}
                       - {{ssc_pkg::JOB_AW{1'b0}}, job_pop_i};
    end
  end

  assign key_o = key_mem[krd_q];
  assign job_o = job_mem[jrd_q];
  assign status_o.key_full  = (kcnt_q == (ssc_pkg::KEY_AW+1)'(ssc_pkg::KEY_DEPTH));
  assign status_o.job_full  = (jcnt_q == (ssc_pkg::JOB_AW+1)'(ssc_pkg::JOB_DEPTH));
  assign status_o.key_valid = (kcnt_q != '0);
  assign status_o.job_valid = (jcnt_q != '0);

  `SSC_NEVER(a_key_overflow, clk_i, rst_ni, key_push_i && status_o.key_full)
  `SSC_NEVER(a_key_underflow, clk_i, rst_ni, key_pop_i && !status_o.key_valid)
  `SSC_NEVER(a_job_overflow, clk_i, rst_ni, job_push_i && status_o.job_full)
  `SSC_NEVER(a_job_underflow, clk_i, rst_ni, job_pop_i && !status_o.job_valid)
endmodule
`default_nettype wire

// File: src/ssc_front.sv
// byte parser: pattern checks, push walk, key walk and per-script job
`default_nettype none
module ssc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [4:0]    cfg_data_i,
  input  wire logic          take_i,
  input  wire ssc_pkg::in_t  in_i,
  output logic               key_push_o,
  output ssc_pkg::key_t      key_o,
  output logic               job_push_o,
  output ssc_pkg::job_t      job_o
);
  logic [4:0]  cap_q;
  logic [13:0] pos_q, pos_d;
  logic [3:0]  flags_q, flags_d;
  logic [7:0]  fo_q, fo_d, prev_q, prev_d;
  ssc_pkg::push_phase_e ph_q, ph_d;
  logic [31:0] skip_q, skip_d;
  logic        nd_q, nd_d, kw_q, kw_d;
  logic [14:0] nkp_q, nkp_d;
  logic [4:0]  kc_q, kc_d;

  logic [7:0]  b;
  logic [14:0] len, p;
  logic        sh_ok, pkh_ok, pkc_ok, pku_ok, fin, key_hit, key_bad, ms, nd_fin;
  logic [15:0] key_end;
  logic [4:0]  m, n;

  always_comb begin
    b = in_i.script_byte;
    if (in_i.script_length == '0) len = 15'd1;
    else if (in_i.script_length > 15'(ssc_pkg::MAX_SCRIPT_BYTES))
      len = 15'(ssc_pkg::MAX_SCRIPT_BYTES);
    else len = in_i.script_length;
    p = {1'b0, pos_q};
  end

  always_comb begin
    sh_ok  = len == 15'd23 && !(p == 15'd0 && b != 8'ha9) && !(p == 15'd1 && b != 8'd20)
             && !(p == 15'd22 && b != 8'h87);
    pkh_ok = len == 15'd25 && !(p == 15'd0 && b != 8'h76) && !(p == 15'd1 && b != 8'ha9)
             && !(p == 15'd2 && b != 8'd20) && !(p == 15'd23 && b != 8'h88)
             && !(p == 15'd24 && b != 8'hac);
    pkc_ok = len == 15'd35 && !(p == 15'd0 && b != 8'd33)
             && !(p == 15'd1 && b != 8'h02 && b != 8'h03) && !(p == 15'd34 && b != 8'hac);
    pku_ok = len == 15'd67 && !(p == 15'd0 && b != 8'd65) && !(p == 15'd1 && b != 8'h04)
             && !(p == 15'd66 && b != 8'hac);
    flags_d = flags_q & {pku_ok, pkc_ok, pkh_ok, sh_ok};
  end

  // null-data push walk
  always_comb begin
    fo_d = fo_q; nd_d = nd_q; ph_d = ph_q; skip_d = skip_q;
    if (p == '0) begin
      fo_d = b;
      if (b != 8'h6a) nd_d = 1'b0;
    end else if (nd_q) begin
      case (ph_q)
        ssc_pkg::PH_OP: begin
          if (skip_q != '0) skip_d = skip_q - 32'd1;
          else if (b <= 8'd75) skip_d = {24'd0, b};
          else if (b == 8'h4c) ph_d = ssc_pkg::PH_L1;
          else if (b == 8'h4d) ph_d = ssc_pkg::PH_L2A;
          else if (b == 8'h4e) ph_d = ssc_pkg::PH_L4A;
          else nd_d = 1'b0;
        end
        ssc_pkg::PH_L1:  begin skip_d = {24'd0, b}; ph_d = ssc_pkg::PH_OP; end
        ssc_pkg::PH_L2A: begin skip_d = {24'd0, b}; ph_d = ssc_pkg::PH_L2B; end
        ssc_pkg::PH_L2B: begin skip_d = skip_q | {16'd0, b, 8'd0}; ph_d = ssc_pkg::PH_OP; end
        ssc_pkg::PH_L4A: begin skip_d = {24'd0, b}; ph_d = ssc_pkg::PH_L4B; end
        ssc_pkg::PH_L4B: begin skip_d = skip_q | {16'd0, b, 8'd0}; ph_d = ssc_pkg::PH_L4C; end
        ssc_pkg::PH_L4C: begin skip_d = skip_q | {8'd0, b, 16'd0}; ph_d = ssc_pkg::PH_L4D; end
        default:         begin skip_d = skip_q | {b, 24'd0}; ph_d = ssc_pkg::PH_OP; end
      endcase
    end
  end

  // multisig key walk
  always_comb begin
    kw_d = kw_q; nkp_d = nkp_q; kc_d = kc_q;
    key_end = {1'b0, p} + 16'd1 + {8'd0, b};
    key_hit = p >= 15'd1 && len >= 15'd4 && p < len - 15'd2 && p == nkp_q && kw_q;
    key_bad = (b != 8'd33 && b != 8'd65) || key_end > {1'b0, len - 15'd2}
              || kc_q >= 5'(ssc_pkg::MAX_KEYS);
    key_push_o = 1'b0;
    key_o.offset = 14'(p + 15'd1);
    key_o.is_long = (b == 8'd65);
    if (key_hit) begin
      if (key_bad) kw_d = 1'b0;
      else begin
        key_push_o = take_i;
        kc_d = kc_q + 5'd1;
        nkp_d = key_end[14:0];
      end
    end
  end

  // final byte: build the job
  always_comb begin
    fin = ({1'b0, p} + 16'd1) >= {1'b0, len};
    prev_d = b;
    // the final byte itself takes part in the push walk
    nd_fin = nd_d && ph_d == ssc_pkg::PH_OP && skip_d == '0;
    m = 5'(fo_q - 8'h50);
    n = 5'(prev_q - 8'h50);
    ms = len >= 15'd4 && p >= 15'd1 && b == 8'hae && prev_q >= 8'h51 && prev_q <= 8'h60
         && fo_q >= 8'h51 && fo_q <= 8'h60 && m <= n
         && ({1'b0, n} + 6'd2) <= {1'b0, cap_q} && n <= 5'(ssc_pkg::MAX_KEYS) && kw_q
         && nkp_q == len - 15'd2 && kc_q == n;
    job_o = '0;
    job_o.matched = 1'b1;
    job_o.nkeys = kc_d;
    job_o.n = n;
    if (flags_d[0] && cap_q != '0) begin
      job_o.script_type = ssc_pkg::TYPE_SH; job_o.kind = ssc_pkg::KIND_RANGE;
      job_o.offset = 14'd2; job_o.length = 7'd20;
    end else if (nd_fin) begin
      job_o.script_type = ssc_pkg::TYPE_NULL;
    end else if (flags_d[1] && cap_q != '0) begin
      job_o.script_type = ssc_pkg::TYPE_PKH; job_o.kind = ssc_pkg::KIND_RANGE;
      job_o.offset = 14'd3; job_o.length = 7'd20;
    end else if (flags_d[2] && cap_q != '0) begin
      job_o.script_type = ssc_pkg::TYPE_PUBKEY; job_o.kind = ssc_pkg::KIND_RANGE;
      job_o.offset = 14'd1; job_o.length = 7'd33;
    end else if (flags_d[3] && cap_q != '0) begin
      job_o.script_type = ssc_pkg::TYPE_PUBKEY; job_o.kind = ssc_pkg::KIND_RANGE;
      job_o.offset = 14'd1; job_o.length = 7'd65;
    end else if (ms) begin
      job_o.script_type = ssc_pkg::TYPE_MULTI; job_o.is_multi = 1'b1; job_o.m = m;
    end else begin
      job_o.matched = 1'b0;
    end
    job_push_o = take_i && fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= ssc_pkg::CAP_RESET;
      pos_q <= '0; flags_q <= 4'hf; fo_q <= '0; prev_q <= '0;
      ph_q <= ssc_pkg::PH_OP; skip_q <= '0; nd_q <= 1'b1;
      nkp_q <= 15'd1; kc_q <= '0; kw_q <= 1'b1;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (take_i) begin
        if (fin) begin
          pos_q <= '0; flags_q <= 4'hf; fo_q <= '0; prev_q <= '0;
          ph_q <= ssc_pkg::PH_OP; skip_q <= '0; nd_q <= 1'b1;
          nkp_q <= 15'd1; kc_q <= '0; kw_q <= 1'b1;
        end else begin
          pos_q <= pos_d; flags_q <= flags_d; fo_q <= fo_d; prev_q <= prev_d;
          ph_q <= ph_d; skip_q <= skip_d; nd_q <= nd_d;
          nkp_q <= nkp_d; kc_q <= kc_d; kw_q <= kw_d;
        end
      end
    end
  end

  assign pos_d = pos_q + 14'd1;
endmodule
`default_nettype wire

// File: src/ssc_back.sv
// result emitter: turns queued jobs into result rows
`default_nettype none
module ssc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ssc_pkg::q_status_t status_i,
  input  wire ssc_pkg::job_t      job_i,
  output logic                    job_pop_o,
  input  wire ssc_pkg::key_t      key_i,
  output logic                    key_pop_o,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output ssc_pkg::out_t           data_o
);
  ssc_pkg::back_state_e st_q, st_d;
  ssc_pkg::job_t job_q;
  logic [4:0] idx_q, idx_d, left_q, left_d;
  logic       ov_q, load;
  ssc_pkg::out_t row, out_q;

  assign load = !ov_q || !stall_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      ssc_pkg::BK_IDLE: if (status_i.job_valid) st_d = ssc_pkg::BK_ROWS;
      ssc_pkg::BK_ROWS: begin
        if (load) begin
          if (!job_q.is_multi) begin
            st_d = (job_q.nkeys != '0) ? ssc_pkg::BK_DRAIN : ssc_pkg::BK_IDLE;
          end else if (idx_q == job_q.n + 5'd1) begin
            st_d = ssc_pkg::BK_IDLE;
          end
        end
      end
      ssc_pkg::BK_DRAIN: if (left_q == 5'd1) st_d = ssc_pkg::BK_IDLE;
      default: st_d = ssc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0; key_pop_o = 1'b0;
    idx_d = idx_q; left_d = left_q;
    row = '0;
    row.script_type = job_q.script_type;
    row.matched = job_q.matched;
    row.solution_index = idx_q;
    case (st_q)
      ssc_pkg::BK_IDLE: begin
        job_pop_o = status_i.job_valid;
        idx_d = '0;
        left_d = job_i.nkeys;
      end
      ssc_pkg::BK_ROWS: begin
        if (!job_q.is_multi) begin
          row.solution_kind = job_q.kind;
          row.solution_offset = job_q.offset;
          row.solution_length = job_q.length;
          row.last_result = 1'b1;
        end else if (idx_q == '0) begin
          row.solution_kind = ssc_pkg::KIND_SMALL;
          row.solution_length = 7'd1;
          row.small_value = job_q.m;
        end else if (idx_q == job_q.n + 5'd1) begin
          row.solution_kind = ssc_pkg::KIND_SMALL;
          row.solution_length = 7'd1;
          row.small_value = job_q.n;
          row.last_result = 1'b1;
        end else begin
          row.solution_kind = ssc_pkg::KIND_RANGE;
          row.solution_offset = key_i.offset;
          row.solution_length = key_i.is_long ? 7'd65 : 7'd33;
          key_pop_o = load;
        end
        if (load) idx_d = idx_q + 5'd1;
      end
      ssc_pkg::BK_DRAIN: begin
        key_pop_o = 1'b1;
        left_d = left_q - 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ssc_pkg::BK_IDLE && status_i.job_valid) job_q <= job_i;
    if (st_q == ssc_pkg::BK_ROWS && load) out_q <= row;
    idx_q <= idx_d;
    left_q <= left_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ssc_pkg::BK_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) ov_q <= (st_q == ssc_pkg::BK_ROWS);
    end
  end

  assign valid_o = ov_q;
  assign data_o = out_q;
endmodule
`default_nettype wire

// File: tb/standard_script_classifier_tb.sv
// self-checking testbench for the standard script classifier
`timescale 1ns / 1ps
module standard_script_classifier_tb;

  // scoreboard: running copy of the classifier's parser state plus the queue of
  // rows still owed by the block
  class script_scoreboard;
    int unsigned capacity;
    int unsigned pos, lead_op, prev_b, phase, nkeys, next_key;
    longint unsigned skip;
    bit nd_ok, walk_ok;
    bit [3:0] cand;
    int unsigned key_off[ssc_pkg::MAX_KEYS];
    bit key_long[ssc_pkg::MAX_KEYS];
    ssc_pkg::out_t owed_rows[$];
    int errors;

    function void clear_script();
      pos = 0; cand = 4'hf; lead_op = 0; prev_b = 0; phase = 0; skip = 0;
      nd_ok = 1; next_key = 1; nkeys = 0; walk_ok = 1;
    endfunction

    function void init();
      capacity = ssc_pkg::CAP_RESET; errors = 0; clear_script();
    endfunction

    function void add_row(logic [2:0] t, logic [1:0] k, int unsigned off,
                          int unsigned len, int unsigned sv, bit last);
      ssc_pkg::out_t r;
      r.script_type = t;
      r.matched = (t != ssc_pkg::TYPE_NONSTD);
      r.solution_index = owed_rows.size() > 0 && !owed_rows[$].last_result ?
                         owed_rows[$].solution_index + 5'd1 : 5'd0;
      r.solution_kind = k;
      r.solution_offset = off[13:0];
      r.solution_length = len[6:0];
      r.small_value = sv[4:0];
      r.last_result = last;
      owed_rows.push_back(r);
    endfunction

    function void push_walk(int unsigned b);
      case (phase)
        0: begin
          if (skip > 0) skip--;
          else if (b <= 75) skip = b;
          else if (b == 'h4c) phase = 1;
          else if (b == 'h4d) phase = 2;
          else if (b == 'h4e) phase = 4;
          else nd_ok = 0;
        end
        1: begin skip = b; phase = 0; end
        2: begin skip = b; phase = 3; end
        3: begin skip |= longint'(b) << 8; phase = 0; end
        4: begin skip = b; phase = 5; end
        5: begin skip |= longint'(b) << 8; phase = 6; end
        6: begin skip |= longint'(b) << 16; phase = 7; end
        default: begin skip |= longint'(b) << 24; phase = 0; end
      endcase
    endfunction

    // notes one accepted byte and queues any rows it completes
    function void note_byte(ssc_pkg::in_t it);
      int unsigned b, len, p, m, n;
      bit ms, nd;
      b = it.script_byte;
      len = it.script_length;
      p = pos;
      if (len == 0) len = 1;
      if (len > ssc_pkg::MAX_SCRIPT_BYTES) len = ssc_pkg::MAX_SCRIPT_BYTES;
      if (len != 23 || (p == 0 && b != 'ha9) || (p == 1 && b != 20) ||
          (p == 22 && b != 'h87)) cand[0] = 0;
      if (len != 25 || (p == 0 && b != 'h76) || (p == 1 && b != 'ha9) ||
          (p == 2 && b != 20) || (p == 23 && b != 'h88) || (p == 24 && b != 'hac))
        cand[1] = 0;
      if (len != 35 || (p == 0 && b != 33) || (p == 1 && b != 2 && b != 3) ||
          (p == 34 && b != 'hac)) cand[2] = 0;
      if (len != 67 || (p == 0 && b != 65) || (p == 1 && b != 4) ||
          (p == 66 && b != 'hac)) cand[3] = 0;
      if (p == 0) begin
        lead_op = b;
        if (b != 'h6a) nd_ok = 0;
      end else if (nd_ok) push_walk(b);
      if (p >= 1 && len >= 4 && p < len - 2 && p == next_key && walk_ok) begin
        if ((b != 33 && b != 65) || p + 1 + b > len - 2 || nkeys >= ssc_pkg::MAX_KEYS)
          walk_ok = 0;
        else begin
          key_off[nkeys] = p + 1; key_long[nkeys] = (b == 65);
          nkeys++; next_key = p + 1 + b;
        end
      end
      if (p + 1 < len) begin
        prev_b = b; pos = p + 1;
        return;
      end
      nd = nd_ok && phase == 0 && skip == 0;
      ms = 0; m = 0; n = 0;
      if (len >= 4 && p >= 1 && b == 'hae && prev_b >= 'h51 && prev_b <= 'h60 &&
          lead_op >= 'h51 && lead_op <= 'h60) begin
        m = lead_op - 'h50; n = prev_b - 'h50;
        ms = m <= n && n + 2 <= capacity && n <= ssc_pkg::MAX_KEYS && walk_ok &&
             next_key == len - 2 && nkeys == n;
      end
      if (cand[0] && capacity >= 1)
        add_row(ssc_pkg::TYPE_SH, ssc_pkg::KIND_RANGE, 2, 20, 0, 1);
      else if (nd)
        add_row(ssc_pkg::TYPE_NULL, ssc_pkg::KIND_NONE, 0, 0, 0, 1);
      else if (cand[1] && capacity >= 1)
        add_row(ssc_pkg::TYPE_PKH, ssc_pkg::KIND_RANGE, 3, 20, 0, 1);
      else if (cand[2] && capacity >= 1)
        add_row(ssc_pkg::TYPE_PUBKEY, ssc_pkg::KIND_RANGE, 1, 33, 0, 1);
      else if (cand[3] && capacity >= 1)
        add_row(ssc_pkg::TYPE_PUBKEY, ssc_pkg::KIND_RANGE, 1, 65, 0, 1);
      else if (ms) begin
        add_row(ssc_pkg::TYPE_MULTI, ssc_pkg::KIND_SMALL, 0, 1, m, 0);
        for (int i = 0; i < n; i++)
          add_row(ssc_pkg::TYPE_MULTI, ssc_pkg::KIND_RANGE, key_off[i],
                  key_long[i] ? 65 : 33, 0, 0);
        add_row(ssc_pkg::TYPE_MULTI, ssc_pkg::KIND_SMALL, 0, 1, n, 1);
      end else add_row(ssc_pkg::TYPE_NONSTD, ssc_pkg::KIND_NONE, 0, 0, 0, 1);
      clear_script();
    endfunction

    function void check_row(ssc_pkg::out_t got);
      ssc_pkg::out_t want;
      if (owed_rows.size() == 0) begin
        $error("unexpected result row %h", got);
        errors++;
        return;
      end
      want = owed_rows.pop_front();
      if (got.script_type !== want.script_type) begin
        $error("script_type exp %0d got %0d", want.script_type, got.script_type); errors++;
      end
      if (got.matched !== want.matched) begin
        $error("matched exp %0d got %0d", want.matched, got.matched); errors++;
      end
      if (got.solution_index !== want.solution_index) begin
        $error("solution_index exp %0d got %0d", want.solution_index,
               got.solution_index); errors++;
      end
      if (got.solution_kind !== want.solution_kind) begin
        $error("solution_kind exp %0d got %0d", want.solution_kind,
               got.solution_kind); errors++;
      end
      if (got.solution_offset !== want.solution_offset) begin
        $error("solution_offset exp %0d got %0d", want.solution_offset,
               got.solution_offset); errors++;
      end
      if (got.solution_length !== want.solution_length) begin
        $error("solution_length exp %0d got %0d", want.solution_length,
               got.solution_length); errors++;
      end
      if (got.small_value !== want.small_value) begin
        $error("small_value exp %0d got %0d", want.small_value, got.small_value); errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result exp %0d got %0d", want.last_result, got.last_result); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [4:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  ssc_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  ssc_pkg::out_t out_data_o;

  script_scoreboard sb;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;
  byte unsigned script_buf[$];

  standard_script_classifier uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // sample both channels at the edge, before any nonblocking update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_row(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver stall, random or a long hold-off when asked
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if (quiet_cycles > 20000) begin
      $display("standard_script_classifier_tb: errors");
      $finish;
    end
  end

  // one byte transaction with random idle cycles in front
  task automatic send_byte(byte unsigned b, int unsigned len);
    ssc_pkg::in_t it;
    it.script_byte = b;
    it.script_length = len[14:0];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sends script_buf as one script, the given length on every byte
  task automatic send_script(int unsigned len);
    foreach (script_buf[i]) send_byte(script_buf[i], len);
    in_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic send_plain();
    send_script(script_buf.size());
  endtask

  // block must be idle: all rows in, then a margin for trailing key drain
  task automatic wait_idle();
    while (sb.owed_rows.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] v);
    wait_idle();
    cfg_we_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.capacity = v;
  endtask

  task automatic fill_random(int n);
    script_buf = {};
    repeat (n) script_buf.push_back(8'($urandom_range(255)));
  endtask

  // well-formed patterns with random payload bytes
  task automatic build_sh();
    fill_random(23); script_buf[0] = 'ha9; script_buf[1] = 20; script_buf[22] = 'h87;
  endtask
  task automatic build_multi(int m, int n, bit mixed);
    script_buf = {};
    script_buf.push_back(8'('h50 + m));
    for (int i = 0; i < n; i++) begin
      int kl;
      kl = (mixed && $urandom_range(3) == 0) ? 65 : 33;
      script_buf.push_back(8'(kl));
      repeat (kl) script_buf.push_back(8'($urandom_range(255)));
    end
    script_buf.push_back(8'('h50 + n));
    script_buf.push_back(8'hae);
  endtask
  task automatic build_null(int pushes);
    script_buf = {};
    script_buf.push_back(8'h6a);
    repeat (pushes) begin
      int k, plen;
      k = $urandom_range(3);
      plen = $urandom_range(2);
      case (k)
        0: script_buf.push_back(8'(plen));
        1: begin script_buf.push_back(8'h4c); script_buf.push_back(8'(plen)); end
        2: begin script_buf.push_back(8'h4d); script_buf.push_back(8'(plen));
          script_buf.push_back(8'h00); end
        default: begin script_buf.push_back(8'h4e); script_buf.push_back(8'(plen));
          repeat (3) script_buf.push_back(8'h00); end
      endcase
      repeat (plen) script_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  // one short random script: noise or null data, the null data sometimes cut short
  task automatic random_script();
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) fill_random($urandom_range(1, 3));
    else build_null($urandom_range(0, 1));
    if (sel >= 50 && $urandom_range(3) == 0 && script_buf.size() > 1)
      void'(script_buf.pop_back());
    send_plain();
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed part: patterns, extremes of the fields and lengths
    build_sh(); send_plain();
    build_multi(1, 1, 0); send_plain();
    script_buf = {8'h6a, 8'h4c, 8'h01, 8'h55}; send_plain();  // one-byte pushdata
    script_buf = {8'h6a, 8'h4c}; send_plain();          // truncated pushdata header
    script_buf = {8'h6a, 8'h05, 8'h01}; send_plain();   // push past the end
    script_buf = {8'h00}; send_script(0);               // zero length acts as one
    script_buf = {8'hff}; send_script(16'h7fff);        // saturated length, then
    fill_random(3); send_script(1);                     // length one finishes it
    // length changing mid-script
    send_byte(8'h52, 5); send_byte(8'hff, 2);
    in_valid_i <= 0;
    @(posedge clk_i);

    write_capacity(5'd0);
    script_buf = {8'h6a}; send_plain();                 // null data does not depend on capacity
    script_buf = {8'h51}; send_plain();

    // long receiver hold-off while bytes keep coming
    write_capacity(5'd20);
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      repeat (8) random_script();
    join

    // random part across idling phases and capacity settings
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 19 : 68) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 19 : 68) : 0;
      write_capacity(ph == 2 ? 5'd0 : 5'($urandom_range(1, 31)));
      repeat (3) random_script();
    end

    wait_idle();
    if (sb.errors == 0)
      $display("standard_script_classifier_tb: clean");
    else
      $display("standard_script_classifier_tb: errors");
    $finish;
  end
endmodule
